### sv/ifs_pkg.sv
// Package for the information frame stuffer: register indexes, reset values
// and the stuffing constants. No dependencies.
package ifs_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned SeqWidth  = 2;
   localparam int unsigned CsrIndexWidth = 2;

   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [SeqWidth-1:0]  seq_type;
   typedef logic [CsrIndexWidth-1:0] csr_index_type;

   // Configuration register indexes
   localparam csr_index_type CSR_FLAG    = 2'd0;
   localparam csr_index_type CSR_ESCAPE  = 2'd1;
   localparam csr_index_type CSR_ADDRESS = 2'd2;

   // Reset values of the configuration registers
   localparam byte_type FLAG_RESET    = 8'h7E;
   localparam byte_type ESCAPE_RESET  = 8'h7D;
   localparam byte_type ADDRESS_RESET = 8'h03;

   // XOR applied to a byte that follows the escape byte
   localparam byte_type STUFF_MASK = 8'h20;

endpackage

### sv/information_frame_stuffer_top.sv
// Top level of the information frame stuffer: framing sequencer, stuffing
// logic and output register. Depends on ifs_pkg.
//
// Usage:
//   req_* : payload bytes in. tdata = payload_byte, tlast = last byte of the
//           frame, tuser = sequence number (taken on a frame's first byte).
//   rsp_* : line bytes out. tdata = line_byte, tlast = last line byte caused
//           by one input transfer, tuser = closing flag of the frame.
//   csr_* : register writes (0 flag, 1 escape, 2 address); always ready.
//           Write only while the block is idle.
// The first line byte of an input transfer is held in the job registers and
// then loaded into the output register before it shows on rsp.
// Throughput: one line byte per cycle while rsp_tready is high. An input
// transfer causes 1 or 2 line bytes for a mid-frame byte, up to 12 for a
// one-byte frame. The single byte-wide output register sets this figure; the
// next input transfer is taken in the cycle that the last line byte of the
// current one is loaded, so successive transfers leave no gap on rsp.
// Reset: clears the frame state, empties the pipeline and reloads the
// register defaults (flag 0x7E, escape 0x7D, address 0x03).
// Stall: while rsp_tready is low the output byte holds, the sequencer holds
// and req_tready drops once the current transfer's bytes are pending.
module information_frame_stuffer_top (
   input  logic       clock,
   input  logic       reset,
   // Input channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] payload_byte
   input  logic       req_tlast,   // last_byte
   input  logic [1:0] req_tuser,   // [1:0] sequence_req
   // Result channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] line_byte
   output logic       rsp_tlast,   // run_last
   output logic       rsp_tuser,   // [0] frame_end
   // Configuration write channel
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   // Sequencer phase codes, in emission order
   localparam logic [2:0] PH_OPEN  = 3'd0;
   localparam logic [2:0] PH_ADDR  = 3'd1;
   localparam logic [2:0] PH_CTRL  = 3'd2;
   localparam logic [2:0] PH_HCS   = 3'd3;
   localparam logic [2:0] PH_DATA  = 3'd4;
   localparam logic [2:0] PH_CHECK = 3'd5;
   localparam logic [2:0] PH_CLOSE = 3'd6;

   // Configuration registers
   ifs_pkg::byte_type flag_ff, escape_ff, address_ff;

   // Frame state, updated on each accepted transfer
   logic              in_frame_ff, in_frame_in;
   ifs_pkg::byte_type parity_ff, parity_in;

   // Current job
   logic              busy_ff, busy_in;
   logic [2:0]        phase_ff, phase_in;
   logic              esc_half_ff, esc_half_in;
   ifs_pkg::byte_type data_ff, data_in;
   logic              last_ff, last_in;
   ifs_pkg::byte_type ctrl_ff, ctrl_in;
   ifs_pkg::byte_type check_ff, check_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   ifs_pkg::byte_type rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_end_ff, rsp_end_in;

   logic              load;        // output register takes a new byte
   logic              req_fire;
   ifs_pkg::byte_type cur_byte;    // unstuffed byte of the current phase
   logic              need_stuff;
   logic              stuffed_phase;
   ifs_pkg::byte_type out_byte;
   logic              out_end;
   logic              step_done;   // current phase finishes with this byte
   logic              job_final;   // this byte is the job's last
   logic [2:0]        phase_next;
   ifs_pkg::byte_type run_parity;

   assign csr_ready = 1'b1;

   assign load       = !rsp_valid_ff || rsp_tready;
   assign req_tready = !busy_ff || (load && job_final);
   assign req_fire   = req_tvalid && req_tready;

   // Select the byte of the current phase
   always_comb begin
      case (phase_ff)
         PH_ADDR:  cur_byte = address_ff;
         PH_CTRL:  cur_byte = ctrl_ff;
         PH_HCS:   cur_byte = address_ff ^ ctrl_ff;
         PH_DATA:  cur_byte = data_ff;
         PH_CHECK: cur_byte = check_ff;
         default:  cur_byte = flag_ff;
      endcase
   end

   assign stuffed_phase = (phase_ff != PH_OPEN) && (phase_ff != PH_CLOSE);
   assign need_stuff    = stuffed_phase && !esc_half_ff &&
                          ((cur_byte == flag_ff) || (cur_byte == escape_ff));

   // Build the line byte: escape first, then the masked value, for a byte that needs stuffing
   always_comb begin
      if (need_stuff) begin
         out_byte = escape_ff;
      end else if (esc_half_ff) begin
         out_byte = cur_byte ^ ifs_pkg::STUFF_MASK;
      end else begin
         out_byte = cur_byte;
      end
   end

   assign out_end   = (phase_ff == PH_CLOSE);
   assign step_done = !need_stuff;
   assign job_final = busy_ff && step_done &&
                      ((phase_ff == PH_CLOSE) || ((phase_ff == PH_DATA) && !last_ff));

   // Advance through header, payload and trailer
   always_comb begin
      case (phase_ff)
         PH_OPEN:  phase_next = PH_ADDR;
         PH_ADDR:  phase_next = PH_CTRL;
         PH_CTRL:  phase_next = PH_HCS;
         PH_HCS:   phase_next = PH_DATA;
         PH_DATA:  phase_next = PH_CHECK;
         PH_CHECK: phase_next = PH_CLOSE;
         default:  phase_next = PH_CLOSE;
      endcase
   end

   // Running parity seen by the incoming byte; restart on a new frame
   assign run_parity = in_frame_ff ? parity_ff : '0;

   always_comb begin
      in_frame_in  = in_frame_ff;
      parity_in    = parity_ff;
      busy_in      = busy_ff;
      phase_in     = phase_ff;
      esc_half_in  = esc_half_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      ctrl_in      = ctrl_ff;
      check_in     = check_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_end_in   = rsp_end_ff;

      if (load) begin
         rsp_valid_in = busy_ff;
         rsp_data_in  = out_byte;
         rsp_last_in  = job_final;
         rsp_end_in   = out_end;
         if (busy_ff) begin
            if (need_stuff) begin
               esc_half_in = 1'b1;
            end else begin
               esc_half_in = 1'b0;
               phase_in    = phase_next;
            end
            if (job_final) begin
               busy_in = 1'b0;
            end
         end
      end

      // Take a new transfer; overrides the job fields just retired
      if (req_fire) begin
         busy_in     = 1'b1;
         esc_half_in = 1'b0;
         phase_in    = in_frame_ff ? PH_DATA : PH_OPEN;
         data_in     = req_tdata;
         last_in     = req_tlast;
         ctrl_in     = {req_tuser, {(ifs_pkg::ByteWidth - ifs_pkg::SeqWidth){1'b0}}};
         check_in    = run_parity ^ req_tdata;
         in_frame_in = !req_tlast;
         parity_in   = req_tlast ? '0 : (run_parity ^ req_tdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff      <= ifs_pkg::FLAG_RESET;
         escape_ff    <= ifs_pkg::ESCAPE_RESET;
         address_ff   <= ifs_pkg::ADDRESS_RESET;
         in_frame_ff  <= 1'b0;
         parity_ff    <= '0;
         busy_ff      <= 1'b0;
         phase_ff     <= PH_OPEN;
         esc_half_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               ifs_pkg::CSR_FLAG:    flag_ff    <= csr_data;
               ifs_pkg::CSR_ESCAPE:  escape_ff  <= csr_data;
               ifs_pkg::CSR_ADDRESS: address_ff <= csr_data;
               default: ;
            endcase
         end
         in_frame_ff  <= in_frame_in;
         parity_ff    <= parity_in;
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         esc_half_ff  <= esc_half_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      last_ff     <= last_in;
      ctrl_ff     <= ctrl_in;
      check_ff    <= check_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_end_ff;

endmodule
